FILE: src/mdd_pkg.sv
`default_nettype none
package mdd_pkg;

  localparam int SPACE_HOLD_DEPTH = 16;
  localparam int CMD_FIFO_DEPTH   = 4;

  localparam int START_LEN  = 11;
  localparam int END_LEN    = 9;
  localparam int FALL_STEPS = 4;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEAD,
    PH_BODY,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    T_NONE,
    T_PAYLOAD,
    T_HOLD,
    T_END
  } tail_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FLUSH,
    B_MARK,
    B_TAIL
  } back_state_e;

  // one request from the classifier to the emitter
  typedef struct packed {
    tail_e       tail;
    logic        flush;
    logic [3:0]  nmark;
    logic [7:0]  data;
    logic        lim;
  } cmd_t;

  function automatic logic [7:0] start_pat(logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd3:    b = 8'h53;
      4'd4:    b = 8'h54;
      4'd5:    b = 8'h41;
      4'd6:    b = 8'h52;
      4'd7:    b = 8'h54;
      default: b = 8'h2D;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] start_fb(logic [3:0] idx);
    logic [3:0] f;
    case (idx)
      4'd2:    f = 4'd1;
      4'd3:    f = 4'd2;
      4'd9:    f = 4'd1;
      4'd10:   f = 4'd2;
      default: f = 4'd0;
    endcase
    return f;
  endfunction

  function automatic logic [7:0] end_pat(logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd3:    b = 8'h45;
      4'd4:    b = 8'h4E;
      4'd5:    b = 8'h44;
      default: b = 8'h5F;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] end_fb(logic [3:0] idx);
    logic [3:0] f;
    case (idx)
      4'd2:    f = 4'd1;
      4'd3:    f = 4'd2;
      4'd7:    f = 4'd1;
      4'd8:    f = 4'd2;
      default: f = 4'd0;
    endcase
    return f;
  endfunction

  function automatic logic [3:0] start_fall(logic [3:0] p, logic [7:0] c);
    logic [3:0] q;
    q = (p >= 4'(START_LEN)) ? 4'd0 : p;
    for (int i = 0; i < FALL_STEPS; i++) begin
      if (q != 4'd0 && start_pat(q) != c) q = start_fb(q);
    end
    return q;
  endfunction

  function automatic logic [3:0] end_fall(logic [3:0] p, logic [7:0] c);
    logic [3:0] q;
    q = (p >= 4'(END_LEN)) ? 4'd0 : p;
    for (int i = 0; i < FALL_STEPS; i++) begin
      if (q != 4'd0 && end_pat(q) != c) q = end_fb(q);
    end
    return q;
  endfunction

endpackage
`default_nettype wire

FILE: src/mdd_fifo.sv
`default_nettype none
module mdd_fifo
  import mdd_pkg::*;
#(
  parameter int DEPTH = CMD_FIFO_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  input  wire logic pop_i,
  output cmd_t      data_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;

  function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = push_i ? inc(wp_q) : wp_q;
    rp_d  = pop_i ? inc(rp_q) : rp_q;
    cnt_d = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule
`default_nettype wire

FILE: src/mdd_front.sv
`default_nettype none
module mdd_front
  import mdd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic [7:0]  stream_byte_i,
  output logic             in_ready_o,
  input  wire logic        cfg_valid_i,
  input  wire logic [15:0] cfg_frame_limit_i,
  output logic             push_o,
  output cmd_t             cmd_o,
  input  wire logic        full_i
);

  phase_e      phase_q, phase_d;
  logic [3:0]  start_q, start_d;
  logic [3:0]  end_q, end_d;
  logic [15:0] frames_q, frames_d;
  logic [15:0] limit_q;

  logic       take, ignore, is_sp, lim;
  logic [3:0] s_f, s_next, e_f, e_n;
  logic       s_hit, s_done, e_hit, e_done;

  assign in_ready_o = !full_i;
  assign take       = in_valid_i && in_ready_o;
  assign ignore     = phase_q == PH_DONE || frames_q >= limit_q;
  assign is_sp      = stream_byte_i == 8'h0A || stream_byte_i == 8'h0D ||
                      stream_byte_i == 8'h20;

  assign s_f    = start_fall(start_q, stream_byte_i);
  assign s_hit  = start_pat(s_f) == stream_byte_i;
  assign s_next = s_f + 4'(s_hit);
  assign s_done = s_hit && s_f == 4'(START_LEN - 1);

  assign e_f    = end_fall(end_q, stream_byte_i);
  assign e_hit  = end_pat(e_f) == stream_byte_i;
  assign e_n    = end_q - e_f;
  assign e_done = e_hit && e_f == 4'(END_LEN - 1);
  assign lim    = ({1'b0, frames_q} + 17'd1) >= {1'b0, limit_q};

  always_comb begin
    phase_d = phase_q;
    if (take && !ignore) begin
      case (phase_q)
        PH_HUNT: begin
          if (s_done) phase_d = PH_LEAD;
        end
        PH_LEAD, PH_BODY: begin
          if (e_done) phase_d = lim ? PH_DONE : PH_HUNT;
          else if (e_n != 4'd0) phase_d = PH_BODY;
          else if (!e_hit && !is_sp) phase_d = PH_BODY;
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  always_comb begin
    start_d  = start_q;
    end_d    = end_q;
    frames_d = frames_q;
    push_o   = 1'b0;
    cmd_o    = '0;
    cmd_o.nmark = e_n;
    cmd_o.data  = stream_byte_i;
    if (take && !ignore) begin
      if (phase_q == PH_HUNT) begin
        start_d = s_done ? 4'd0 : s_next;
        if (s_done) end_d = 4'd0;
      end else if (phase_q == PH_LEAD || phase_q == PH_BODY) begin
        if (e_done) begin
          push_o      = 1'b1;
          cmd_o.tail  = T_END;
          cmd_o.nmark = 4'd0;
          cmd_o.data  = 8'h00;
          cmd_o.lim   = lim;
          end_d       = 4'd0;
          start_d     = 4'd0;
          frames_d    = frames_q + 16'd1;
        end else if (e_hit) begin
          end_d       = e_f + 4'd1;
          push_o      = e_n != 4'd0;
          cmd_o.tail  = T_NONE;
          cmd_o.flush = 1'b1;
        end else if (is_sp) begin
          end_d       = 4'd0;
          push_o      = !(phase_q == PH_LEAD && e_n == 4'd0);
          cmd_o.tail  = T_HOLD;
          cmd_o.flush = e_n != 4'd0;
        end else begin
          end_d       = 4'd0;
          push_o      = 1'b1;
          cmd_o.tail  = T_PAYLOAD;
          cmd_o.flush = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      start_q  <= '0;
      end_q    <= '0;
      frames_q <= '0;
      limit_q  <= 16'd1;
    end else begin
      phase_q  <= phase_d;
      start_q  <= start_d;
      end_q    <= end_d;
      frames_q <= frames_d;
      if (cfg_valid_i) limit_q <= cfg_frame_limit_i;
    end
  end

endmodule
`default_nettype wire

FILE: src/mdd_back.sv
`default_nettype none
module mdd_back
  import mdd_pkg::*;
#(
  parameter int DEPTH = SPACE_HOLD_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  head_i,
  input  wire logic  empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic       kind_o,
  output logic [7:0] payload_o,
  output logic       limit_reached_o,
  output logic       last_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  back_state_e   state_q, state_d;
  cmd_t          cmd_q, cmd_d;
  logic [3:0]    idx_q, idx_d;
  logic [PW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    held_q [DEPTH];

  logic       ov_q, kind_q, lim_q, last_q;
  logic [7:0] pay_q;

  logic       room, full, more_after;
  logic       emit, e_kind, e_lim, e_last;
  logic [7:0] e_pay;
  logic       wr_en;

  function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign room       = !ov_q || out_ready_i;
  assign full       = cnt_q == CW'(DEPTH);
  assign more_after = cmd_q.tail == T_PAYLOAD;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          if (head_i.flush && cnt_q != '0) state_d = B_FLUSH;
          else if (head_i.nmark != 4'd0) state_d = B_MARK;
          else state_d = B_TAIL;
        end
      end
      B_FLUSH: begin
        if (room && cnt_q == CW'(1)) state_d = (cmd_q.nmark != 4'd0) ? B_MARK : B_TAIL;
      end
      B_MARK: begin
        if (room && idx_q == cmd_q.nmark - 4'd1) state_d = B_TAIL;
      end
      B_TAIL: begin
        case (cmd_q.tail)
          T_PAYLOAD, T_END: if (room) state_d = B_IDLE;
          T_HOLD:           if (room || !full) state_d = B_IDLE;
          default:          state_d = B_IDLE;
        endcase
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o  = 1'b0;
    cmd_d  = cmd_q;
    idx_d  = idx_q;
    rd_d   = rd_q;
    wr_d   = wr_q;
    cnt_d  = cnt_q;
    wr_en  = 1'b0;
    emit   = 1'b0;
    e_kind = 1'b0;
    e_pay  = held_q[rd_q];
    e_lim  = 1'b0;
    e_last = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          idx_d = 4'd0;
        end
      end
      B_FLUSH: begin
        if (room) begin
          emit   = 1'b1;
          e_last = cnt_q == CW'(1) && cmd_q.nmark == 4'd0 && !more_after;
          rd_d   = inc(rd_q);
          cnt_d  = cnt_q - CW'(1);
        end
      end
      B_MARK: begin
        e_pay = end_pat(idx_q);
        if (room) begin
          emit   = 1'b1;
          e_last = idx_q == cmd_q.nmark - 4'd1 && !more_after;
          idx_d  = idx_q + 4'd1;
        end
      end
      B_TAIL: begin
        case (cmd_q.tail)
          T_PAYLOAD: begin
            e_pay = cmd_q.data;
            if (room) begin
              emit   = 1'b1;
              e_last = 1'b1;
            end
          end
          T_END: begin
            e_pay  = 8'h00;
            e_kind = 1'b1;
            e_lim  = cmd_q.lim;
            if (room) begin
              emit   = 1'b1;
              e_last = 1'b1;
              rd_d   = '0;
              wr_d   = '0;
              cnt_d  = '0;
            end
          end
          T_HOLD: begin
            if (full) begin
              // evict oldest, new byte reuses its slot
              if (room) begin
                emit   = 1'b1;
                e_last = 1'b1;
                rd_d   = inc(rd_q);
                wr_en  = 1'b1;
                wr_d   = inc(wr_q);
              end
            end else begin
              wr_en = 1'b1;
              wr_d  = inc(wr_q);
              cnt_d = cnt_q + CW'(1);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      idx_q   <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      cnt_q   <= cnt_d;
      if (emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (wr_en) held_q[wr_q] <= cmd_q.data;
    if (emit) begin
      kind_q <= e_kind;
      pay_q  <= e_pay;
      lim_q  <= e_lim;
      last_q <= e_last;
    end
  end

  assign out_valid_o     = ov_q;
  assign kind_o          = kind_q;
  assign payload_o       = pay_q;
  assign limit_reached_o = lim_q;
  assign last_o          = last_q;

endmodule
`default_nettype wire

FILE: src/marker_delimited_deframer.sv
// channel   direction  handshake                  payload
// input     in         in_valid_i / in_ready_o    stream_byte_i
// result    out        out_valid_o / out_ready_i  kind_o payload_o limit_reached_o last_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_frame_limit_i
//
// Front classifies one byte per cycle while the request queue has room; bytes that
// cause nothing (hunting, marker progress, ignored) never enter the queue.
// Back fetches a request, then emits any flushed held bytes, then any released end-marker
// bytes, and then handles the tail, in that order.
// Reset clears matcher state, frame count, queue and hold; frame_limit resets to 1.
// A stalled output stalls the back only; the front keeps taking bytes until full.
`default_nettype none
module marker_delimited_deframer
  import mdd_pkg::*;
#(
  parameter int SPACE_HOLD_DEPTH = mdd_pkg::SPACE_HOLD_DEPTH,
  parameter int CMD_DEPTH        = CMD_FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  stream_byte_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_frame_limit_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [7:0]       payload_o,
  output logic             limit_reached_o,
  output logic             last_o
);

  cmd_t push_cmd, head_cmd;
  logic push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  mdd_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .stream_byte_i     (stream_byte_i),
    .in_ready_o        (in_ready_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_frame_limit_i (cfg_frame_limit_i),
    .push_o            (push),
    .cmd_o             (push_cmd),
    .full_i            (full)
  );

  mdd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  mdd_back #(
    .DEPTH (SPACE_HOLD_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_cmd),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .payload_o       (payload_o),
    .limit_reached_o (limit_reached_o),
    .last_o          (last_o)
  );

endmodule
`default_nettype wire

FILE: tb/sv/tb_marker_delimited_deframer.sv
`default_nettype none
module tb_marker_delimited_deframer;
  import mdd_pkg::*;

  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [8*START_LEN-1:0] START_MARK = "---START---";
  localparam logic [8*END_LEN-1:0]   END_MARK   = "___END___";
  // fallback length per match length, one nibble each, match length 0 leftmost
  localparam logic [4*(START_LEN+1)-1:0] START_BACK = 48'h001200000123;
  localparam logic [4*(END_LEN+1)-1:0]   END_BACK   = 40'h0012000123;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    logic       lim;
    logic       last;
  } deframe_res_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_SILENT,
    CHK_ECHO,
    CHK_FRAME_END
  } row_check_e;

  typedef struct packed {
    logic [7:0] b;
    row_check_e how;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_ready_o;
  logic [7:0]  stream_byte_i     = 8'h00;
  logic        cfg_valid_i       = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_frame_limit_i = 16'h0000;
  logic        out_valid_o;
  logic        out_ready_i       = 1'b0;
  logic        kind_o;
  logic [7:0]  payload_o;
  logic        limit_reached_o;
  logic        last_o;

  marker_delimited_deframer u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .stream_byte_i     (stream_byte_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_frame_limit_i (cfg_frame_limit_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .payload_o         (payload_o),
    .limit_reached_o   (limit_reached_o),
    .last_o            (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tracked copy of the block state
  phase_e      trk_phase  = PH_HUNT;
  int          trk_start  = 0;
  int          trk_end    = 0;
  logic [7:0]  trk_hold [SPACE_HOLD_DEPTH];
  int          trk_held   = 0;
  logic [15:0] trk_frames = 16'd0;
  logic [15:0] trk_limit  = 16'd1;

  deframe_res_t step_res_q[$];
  deframe_res_t expected_res_q[$];
  deframe_res_t head_res;
  logic [7:0]   tx_q[$];

  int errors = 0;
  int quiet  = 0;
  bit calm   = 1'b0;

  // leading zero byte, start, space, payload byte, end-marker prefix, CR, full end marker
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{8'h00, CHK_SILENT},
    '{"-", CHK_SILENT}, '{"-", CHK_SILENT}, '{"-", CHK_SILENT},
    '{"S", CHK_SILENT}, '{"T", CHK_SILENT}, '{"A", CHK_SILENT},
    '{"R", CHK_SILENT}, '{"T", CHK_SILENT},
    '{"-", CHK_SILENT}, '{"-", CHK_SILENT}, '{"-", CHK_SILENT},
    '{8'h20, CHK_SILENT},
    '{8'hFF, CHK_ECHO},
    '{"_", CHK_SILENT},
    '{8'h0D, CHK_MODEL},
    '{"_", CHK_SILENT}, '{"_", CHK_SILENT}, '{"_", CHK_SILENT},
    '{"E", CHK_SILENT}, '{"N", CHK_SILENT}, '{"D", CHK_SILENT},
    '{"_", CHK_SILENT}, '{"_", CHK_SILENT}, '{"_", CHK_FRAME_END}
  };

  function automatic logic [7:0] start_ch(int p);
    return START_MARK[8*(START_LEN-1-p) +: 8];
  endfunction

  function automatic logic [7:0] end_ch(int p);
    return END_MARK[8*(END_LEN-1-p) +: 8];
  endfunction

  function automatic int start_back(int p);
    return int'(START_BACK[4*(START_LEN-p) +: 4]);
  endfunction

  function automatic int end_back(int p);
    return int'(END_BACK[4*(END_LEN-p) +: 4]);
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h0A || c == 8'h0D || c == 8'h20;
  endfunction

  function automatic void emit_res(logic k, logic [7:0] d, logic l);
    step_res_q.push_back(deframe_res_t'{kind: k, payload: d, lim: l, last: 1'b0});
  endfunction

  function automatic void release_body(logic [7:0] d);
    for (int i = 0; i < trk_held; i++) emit_res(1'b0, trk_hold[i], 1'b0);
    trk_held = 0;
    emit_res(1'b0, d, 1'b0);
    trk_phase = PH_BODY;
  endfunction

  task automatic deframe_byte(input logic [7:0] c);
    int p;
    int f;
    bit lim;
    step_res_q.delete();
    if (trk_phase == PH_DONE || trk_frames >= trk_limit) return;
    if (trk_phase == PH_HUNT) begin
      p = (trk_start >= START_LEN) ? 0 : trk_start;
      while (p > 0 && start_ch(p) != c) p = start_back(p);
      if (start_ch(p) == c) p++;
      if (p == START_LEN) begin
        trk_start = 0;
        trk_end   = 0;
        trk_held  = 0;
        trk_phase = PH_LEAD;
      end else begin
        trk_start = p;
      end
    end else begin
      p = (trk_end >= END_LEN) ? 0 : trk_end;
      while (p > 0 && end_ch(p) != c) begin
        f = end_back(p);
        for (int i = 0; i < p - f; i++) release_body(end_ch(i));
        p = f;
      end
      if (end_ch(p) == c) begin
        p++;
        if (p == END_LEN) begin
          trk_held   = 0;
          trk_end    = 0;
          trk_start  = 0;
          trk_frames = trk_frames + 16'd1;
          lim = trk_frames >= trk_limit;
          emit_res(1'b1, 8'h00, lim);
          trk_phase = lim ? PH_DONE : PH_HUNT;
        end else begin
          trk_end = p;
        end
      end else begin
        trk_end = 0;
        if (is_blank(c)) begin
          if (trk_phase != PH_LEAD) begin
            if (trk_held >= SPACE_HOLD_DEPTH) begin
              emit_res(1'b0, trk_hold[0], 1'b0);
              for (int i = 0; i < SPACE_HOLD_DEPTH - 1; i++) trk_hold[i] = trk_hold[i+1];
              trk_held = SPACE_HOLD_DEPTH - 1;
            end
            trk_hold[trk_held] = c;
            trk_held++;
          end
        end else begin
          release_body(c);
        end
      end
    end
    if (step_res_q.size() != 0) step_res_q[$].last = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] b, input row_check_e how);
    deframe_byte(b);
    case (how)
      CHK_SILENT: step_res_q.delete();
      CHK_ECHO: begin
        step_res_q.delete();
        step_res_q.push_back(deframe_res_t'{kind: 1'b0, payload: b, lim: 1'b0, last: 1'b1});
      end
      CHK_FRAME_END: begin
        step_res_q.delete();
        step_res_q.push_back(deframe_res_t'{kind: 1'b1, payload: 8'h00, lim: 1'b0,
                                            last: 1'b1});
      end
      default: ;
    endcase
    while (step_res_q.size() != 0) expected_res_q.push_back(step_res_q.pop_front());
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_res_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_frame_limit_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    trk_limit = v;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) tx_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 2))
      0:       return 8'h0A;
      1:       return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  task automatic queue_chunk();
    int segs;
    int k;
    if ($urandom_range(0, 9) < 3) begin
      if ($urandom_range(0, 1) == 0) push_str("---STAR");
      repeat ($urandom_range(1, 6)) tx_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) tx_q.push_back(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 5))
        0:       push_str("---STA");
        1:       push_str("--");
        default: ;
      endcase
      push_str("---START---");
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) tx_q.push_back(any_blank());
      segs = $urandom_range(1, 5);
      repeat (segs) begin
        case ($urandom_range(0, 4))
          0: repeat ($urandom_range(1, 4)) tx_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
          1: begin
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 3);
            repeat (k) tx_q.push_back(any_blank());
          end
          2: begin
            k = $urandom_range(1, END_LEN - 1);
            for (int i = 0; i < k; i++) tx_q.push_back(end_ch(i));
          end
          3: tx_q.push_back(8'($urandom_range(0, 255)));
          default: begin
            repeat ($urandom_range(1, 17)) tx_q.push_back(any_blank());
            k = $urandom_range(1, END_LEN - 1);
            for (int i = 0; i < k; i++) tx_q.push_back(end_ch(i));
            tx_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
          end
        endcase
      end
      if ($urandom_range(0, 9) != 0) push_str("___END___");
    end
  endtask

  task automatic run_stream(input int n);
    for (int i = 0; i < n; i++) begin
      if (tx_q.size() == 0) queue_chunk();
      send_byte(tx_q.pop_front(), CHK_MODEL);
    end
  endtask

  task automatic run_noise(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)), CHK_MODEL);
  endtask

  task automatic report_field(input string name, input int want, input int got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_res_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d payload %0h",
                 $time, kind_o, payload_o);
        $display("%0t: lim %0d last %0d", $time, limit_reached_o, last_o);
      end else begin
        head_res = expected_res_q.pop_front();
        if (kind_o !== head_res.kind) report_field("kind", head_res.kind, kind_o);
        if (payload_o !== head_res.payload) report_field("payload", head_res.payload, payload_o);
        if (limit_reached_o !== head_res.lim)
          report_field("limit_reached", head_res.lim, limit_reached_o);
        if (last_o !== head_res.last) report_field("last", head_res.last, last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 25)) @(posedge clk_i);
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_limit(16'hFFFF);

    for (int r = 0; r < DIR_ROWS; r++) send_byte(dir_tab[r].b, dir_tab[r].how);

    run_stream(40);
    drain_results();
    run_stream(40);

    // limit at most frames done, then zero: all ignored
    write_limit(16'd1);
    run_noise(8);
    write_limit(16'd0);
    run_noise(8);
    write_limit(16'hFFFF);

    run_stream(70);

    calm = 1'b1;
    write_limit(trk_frames + 16'($urandom_range(2, 4)));
    for (int i = 0; i < 600 && trk_phase != PH_DONE; i++) begin
      if (tx_q.size() == 0) queue_chunk();
      send_byte(tx_q.pop_front(), CHK_MODEL);
    end
    run_noise(6);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
